FILE: design/svov_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sensor reading outlier validator
// no dependencies; used by every module under design/

package svov_pkg;

  localparam int LANES = 4;
  localparam int VAL_W = 12;
  localparam int LUX_W = 18;
  localparam int MASK_W = 4;
  localparam int LIM_W = 10;
  localparam int PERIOD_W = 27;

  // limit unit geometry: multiply stage, then offset and cap stage
  localparam int LIM_STEPS = 2;
  localparam int CNT_W = 2;
  localparam int QUO_W = 11;
  localparam int NUM_W = 25;
  localparam int RCP_W = 31;
  localparam int RCP_SHIFT = 44;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int OFF_W = 7;

  localparam logic [PERIOD_W-1:0] MINUTE_MS = PERIOD_W'(60000);
  localparam logic [PERIOD_W-1:0] HOUR_MS = PERIOD_W'(3600000);
  // from here on both change limits sit at their caps
  localparam logic [PERIOD_W-1:0] CAP_MS = PERIOD_W'(10000000);

  // ceil(2^RCP_SHIFT / d): (x * rcp) >> RCP_SHIFT equals floor(x / d) for any
  // numerator of NUM_W bits
  localparam logic [RCP_W-1:0] RCP_T_MID =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd359999) / 64'd360000);
  localparam logic [RCP_W-1:0] RCP_H_MID =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd23999) / 64'd24000);
  localparam logic [RCP_W-1:0] RCP_T_HIGH =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd19999) / 64'd20000);
  localparam logic [RCP_W-1:0] RCP_H_HIGH =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd9599) / 64'd9600);

  localparam logic [OFF_W-1:0] OFF_T_MID = OFF_W'(50);
  localparam logic [OFF_W-1:0] OFF_H_MID = OFF_W'(100);

  localparam logic [LIM_W-1:0] TLIM_SHORT = LIM_W'(50);
  localparam logic [LIM_W-1:0] HLIM_SHORT = LIM_W'(100);
  localparam logic [LIM_W-1:0] TLIM_CAP = LIM_W'(500);
  localparam logic [LIM_W-1:0] HLIM_CAP = LIM_W'(1000);
  // limits for the reset period of 600000 ms
  localparam logic [LIM_W-1:0] TLIM_RESET = LIM_W'(61);
  localparam logic [LIM_W-1:0] HLIM_RESET = LIM_W'(125);

  localparam logic signed [LUX_W-1:0] LUX_LO = LUX_W'(0);
  localparam logic signed [LUX_W-1:0] LUX_HI = LUX_W'(100000);

  typedef enum logic [3:0] {
    RSN_OK          = 4'd0,
    RSN_MISSING     = 4'd1,
    RSN_RANGE_AT    = 4'd2,
    RSN_RANGE_AH    = 4'd3,
    RSN_RANGE_ST    = 4'd4,
    RSN_RANGE_SH    = 4'd5,
    RSN_RANGE_LIGHT = 4'd6,
    RSN_JUMP_AT     = 4'd7,
    RSN_JUMP_AH     = 4'd8,
    RSN_JUMP_ST     = 4'd9,
    RSN_JUMP_SH     = 4'd10
  } reason_t;

  typedef logic signed [VAL_W-1:0] val_t;

  // lane order: air temp, air humidity, soil temp, soil humidity
  localparam val_t LANE_LO [LANES] = '{
    VAL_W'(-400), VAL_W'(0), VAL_W'(-400), VAL_W'(0)};
  localparam val_t LANE_HI [LANES] = '{
    VAL_W'(800), VAL_W'(1000), VAL_W'(850), VAL_W'(1000)};
  localparam logic LANE_IS_HUM [LANES] = '{1'b0, 1'b1, 1'b0, 1'b1};
  localparam reason_t RANGE_CODE [LANES] = '{
    RSN_RANGE_AT, RSN_RANGE_AH, RSN_RANGE_ST, RSN_RANGE_SH};
  localparam reason_t JUMP_CODE [LANES] = '{
    RSN_JUMP_AT, RSN_JUMP_AH, RSN_JUMP_ST, RSN_JUMP_SH};

  typedef struct packed {
    logic range_bad;
    logic jump_bad;
  } lane_flags_t;

  typedef struct packed {
    logic busy;
    logic [LIM_W-1:0] temp_lim;
    logic [LIM_W-1:0] hum_lim;
  } limits_t;

endpackage

FILE: design/svov_limit_unit.sv
`timescale 1ns / 1ps
// change limits from the sampling period: reciprocal multiply, then offset and cap
// depends on svov_pkg

module svov_limit_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [svov_pkg::PERIOD_W-1:0] cfg_wdata,
  output svov_pkg::limits_t limits
);

  logic [svov_pkg::CNT_W-1:0] cnt;
  logic [svov_pkg::LIM_W-1:0] temp_lim;
  logic [svov_pkg::LIM_W-1:0] hum_lim;
  logic [svov_pkg::NUM_W-1:0] tnum;
  logic [svov_pkg::NUM_W-1:0] hnum;
  logic [svov_pkg::RCP_W-1:0] trcp;
  logic [svov_pkg::RCP_W-1:0] hrcp;
  logic [svov_pkg::QUO_W-1:0] tq;
  logic [svov_pkg::QUO_W-1:0] hq;
  logic [svov_pkg::OFF_W-1:0] toff;
  logic [svov_pkg::OFF_W-1:0] hoff;

  logic [svov_pkg::PROD_W-1:0] tprod;
  logic [svov_pkg::PROD_W-1:0] hprod;
  logic [svov_pkg::QUO_W-1:0] tsum;
  logic [svov_pkg::QUO_W-1:0] hsum;
  logic [svov_pkg::PERIOD_W+2:0] p_times7;

  assign p_times7 = ({3'b000, cfg_wdata} << 3) - {3'b000, cfg_wdata};

  always_comb begin
    tprod = svov_pkg::PROD_W'(tnum) * svov_pkg::PROD_W'(trcp);
    hprod = svov_pkg::PROD_W'(hnum) * svov_pkg::PROD_W'(hrcp);
    tsum = svov_pkg::QUO_W'(toff) + tq;
    hsum = svov_pkg::QUO_W'(hoff) + hq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      temp_lim <= svov_pkg::TLIM_RESET;
      hum_lim <= svov_pkg::HLIM_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata < svov_pkg::MINUTE_MS) begin
        cnt <= '0;
        temp_lim <= svov_pkg::TLIM_SHORT;
        hum_lim <= svov_pkg::HLIM_SHORT;
      end else if (cfg_wdata >= svov_pkg::CAP_MS) begin
        cnt <= '0;
        temp_lim <= svov_pkg::TLIM_CAP;
        hum_lim <= svov_pkg::HLIM_CAP;
      end else begin
        cnt <= svov_pkg::CNT_W'(svov_pkg::LIM_STEPS);
      end
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == svov_pkg::CNT_W'(1)) begin
        temp_lim <= tsum[svov_pkg::LIM_W-1:0];
        hum_lim <= (hsum > svov_pkg::QUO_W'(svov_pkg::HLIM_CAP)) ?
                   svov_pkg::HLIM_CAP : hsum[svov_pkg::LIM_W-1:0];
      end
    end
  end

  // quotient datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      if (cfg_wdata < svov_pkg::HOUR_MS) begin
        // 70p/3.6e6 = 7p/360000, 150p/3.6e6 = p/24000
        tnum <= p_times7[svov_pkg::NUM_W-1:0];
        hnum <= cfg_wdata[svov_pkg::NUM_W-1:0];
        trcp <= svov_pkg::RCP_T_MID;
        hrcp <= svov_pkg::RCP_H_MID;
        toff <= svov_pkg::OFF_T_MID;
        hoff <= svov_pkg::OFF_H_MID;
      end else begin
        // 180p/3.6e6 = p/20000, 375p/3.6e6 = p/9600
        tnum <= cfg_wdata[svov_pkg::NUM_W-1:0];
        hnum <= cfg_wdata[svov_pkg::NUM_W-1:0];
        trcp <= svov_pkg::RCP_T_HIGH;
        hrcp <= svov_pkg::RCP_H_HIGH;
        toff <= '0;
        hoff <= '0;
      end
    end else if (cnt == svov_pkg::CNT_W'(svov_pkg::LIM_STEPS)) begin
      tq <= tprod[svov_pkg::RCP_SHIFT +: svov_pkg::QUO_W];
      hq <= hprod[svov_pkg::RCP_SHIFT +: svov_pkg::QUO_W];
    end
  end

  assign limits.busy = cnt != '0;
  assign limits.temp_lim = temp_lim;
  assign limits.hum_lim = hum_lim;

endmodule

FILE: design/svov_lane.sv
`timescale 1ns / 1ps
// one reading channel: range check and change against the last stored value
// depends on svov_pkg

module svov_lane (
  input  svov_pkg::val_t value,
  input  svov_pkg::val_t last,
  input  svov_pkg::val_t lo,
  input  svov_pkg::val_t hi,
  input  logic [svov_pkg::LIM_W-1:0] lim,
  output svov_pkg::lane_flags_t flags
);

  logic signed [svov_pkg::VAL_W:0] diff;
  logic [svov_pkg::VAL_W:0] mag;

  always_comb begin
    diff = {value[svov_pkg::VAL_W-1], value} - {last[svov_pkg::VAL_W-1], last};
    mag = diff[svov_pkg::VAL_W] ? (~diff + 1'b1) : diff;
    flags.range_bad = (value < lo) || (value > hi);
    flags.jump_bad = mag > (svov_pkg::VAL_W + 1)'(lim);
  end

endmodule

FILE: design/svov_merge.sv
`timescale 1ns / 1ps
// folds the lane findings into one reason code, first failing check wins
// depends on svov_pkg

module svov_merge (
  input  logic [svov_pkg::MASK_W-1:0] missing_mask,
  input  logic light_bad,
  input  logic history_present,
  input  svov_pkg::lane_flags_t flags [svov_pkg::LANES],
  output svov_pkg::reason_t reason,
  output logic reading_ok
);

  always_comb begin
    reason = svov_pkg::RSN_OK;
    // walk from lowest priority up so the earliest check overrides
    if (history_present) begin
      for (int i = svov_pkg::LANES - 1; i >= 0; i--) begin
        if (flags[i].jump_bad) begin
          reason = svov_pkg::JUMP_CODE[i];
        end
      end
    end
    if (light_bad) begin
      reason = svov_pkg::RSN_RANGE_LIGHT;
    end
    for (int i = svov_pkg::LANES - 1; i >= 0; i--) begin
      if (flags[i].range_bad) begin
        reason = svov_pkg::RANGE_CODE[i];
      end
    end
    if (|missing_mask) begin
      reason = svov_pkg::RSN_MISSING;
    end
    reading_ok = reason == svov_pkg::RSN_OK;
  end

endmodule

FILE: design/sensor_reading_outlier_validator.sv
`timescale 1ns / 1ps
// sensor reading outlier validator, top level
// depends on svov_pkg, svov_limit_unit, svov_lane, svov_merge
//
// s_axis carries one sensor record per request, m_axis returns one verdict
// per record: reading_ok and the reason code of the first failing check.
// four lanes check air/soil temperature and humidity in parallel (range and
// change against the last passing record), light gets a range check only.
// m_axis_tvalid rises in the cycle after s_axis acceptance. one record is
// taken every cycle while the limits are idle and the receiver keeps up,
// since the check and the history update both finish in the accepting
// cycle. the result sits in an output register; when the receiver stalls,
// a new request is still taken in the cycle the held result leaves,
// otherwise s_axis_tready drops. cfg_we writes the sampling period. for
// periods from one minute up to the cap point the change limits come from
// a reciprocal multiply and an offset stage, with s_axis_tready low while
// they run; other periods take effect on the next cycle.
// rst (synchronous) clears the history, empties the output register and
// restores the 600000 ms period limits.

module sensor_reading_outlier_validator (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [26:0] cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // air_temperature, air_humidity, soil_temperature, soil_humidity,
  // light_level, zero pad
  input  logic [71:0] s_axis_tdata,
  // missing_mask
  input  logic [3:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // reading_ok, reject_reason, zero pad
  output logic [7:0] m_axis_tdata
);

  svov_pkg::limits_t limits;
  svov_pkg::val_t value [svov_pkg::LANES];
  svov_pkg::val_t last [svov_pkg::LANES];
  svov_pkg::lane_flags_t flags [svov_pkg::LANES];
  logic signed [svov_pkg::LUX_W-1:0] light_level;
  logic light_bad;
  logic history_present;
  svov_pkg::reason_t reason;
  logic reading_ok;
  logic accept;

  logic out_valid;
  logic out_ok;
  svov_pkg::reason_t out_reason;

  svov_limit_unit u_limit (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .limits(limits)
  );

  assign light_level = s_axis_tdata[4*svov_pkg::VAL_W +: svov_pkg::LUX_W];
  assign light_bad = (light_level < svov_pkg::LUX_LO) || (light_level > svov_pkg::LUX_HI);

  for (genvar g = 0; g < svov_pkg::LANES; g++) begin : g_lane
    assign value[g] = s_axis_tdata[g*svov_pkg::VAL_W +: svov_pkg::VAL_W];

    svov_lane u_lane (
      .value(value[g]),
      .last(last[g]),
      .lo(svov_pkg::LANE_LO[g]),
      .hi(svov_pkg::LANE_HI[g]),
      .lim(svov_pkg::LANE_IS_HUM[g] ? limits.hum_lim : limits.temp_lim),
      .flags(flags[g])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        last[g] <= '0;
      end else if (accept && reading_ok) begin
        last[g] <= value[g];
      end
    end
  end

  svov_merge u_merge (
    .missing_mask(s_axis_tuser),
    .light_bad(light_bad),
    .history_present(history_present),
    .flags(flags),
    .reason(reason),
    .reading_ok(reading_ok)
  );

  assign s_axis_tready = !limits.busy && (!out_valid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_present <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && reading_ok) begin
        history_present <= 1'b1;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok <= reading_ok;
      out_reason <= reason;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, out_reason, out_ok};

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    limits.busy |-> !s_axis_tready)
    else $error("record taken while limits are being computed");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok == (out_reason == svov_pkg::RSN_OK)))
    else $error("reading_ok disagrees with reason code");

  a_pass_sets_history: assert property (@(posedge clk) disable iff (rst)
    (accept && reading_ok) |=> (history_present && out_valid && out_ok))
    else $error("passing record not stored or not reported");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !reading_ok) |=> ($stable(history_present) && $stable(last[0])
                                 && $stable(last[3])))
    else $error("rejected record changed the stored history");

  a_no_jump_without_history: assert property (@(posedge clk) disable iff (rst)
    (accept && !history_present) |-> (reason != svov_pkg::RSN_JUMP_AT
      && reason != svov_pkg::RSN_JUMP_AH && reason != svov_pkg::RSN_JUMP_ST
      && reason != svov_pkg::RSN_JUMP_SH))
    else $error("change check applied before any stored record");

endmodule
